@@ rtl/core/sorted_priority_queue_core_assert.svh @@
// Assertion macros used by the checker of the priority queue.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("priority queue assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("priority queue assertion failed");

`endif

@@ rtl/core/spq_pkg.sv @@
// Package with sizes, codes and types of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned ENTRY_W = KEY_W + PAY_W;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // Register index of the order mode register
  localparam int unsigned REG_ORDER_MODE = 0;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } seq_state_e;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic               req;
    logic               pop;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    status_e            status;
    logic [CNT_W-1:0]   count;
  } res_t;

  // Step a ring pointer forward, wrapping at the last slot.
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Step a ring pointer backward, wrapping at slot zero.
  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

@@ rtl/core/spq_ram.sv @@
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/spq_cmp.sv @@
// Key comparator: tells whether key a stands strictly before key b.
`timescale 1ns / 1ps

module spq_cmp
  import spq_pkg::*;
(
  input  logic [KEY_W-1:0] key_a_i,
  input  logic [KEY_W-1:0] key_b_i,
  input  logic             mode_i,
  output logic             before_o
);

  logic a_lt_b;
  logic a_gt_b;

  // Two magnitude compares, the order mode picks one
  assign a_lt_b   = key_a_i < key_b_i;
  assign a_gt_b   = key_b_i < key_a_i;
  assign before_o = mode_i ? a_gt_b : a_lt_b;

endmodule

@@ rtl/core/spq_seq.sv @@
// Sequencer: ring-buffer store, insertion search and shift, head removal.
`timescale 1ns / 1ps

module spq_seq
  import spq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [PAY_W-1:0] payload_i,
  output res_t             res_o,
  input  logic             res_take_i
);

  seq_state_e       state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] sh_idx_q, sh_idx_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;
  status_e          status_q, status_d;
  logic             pop_q, pop_d;

  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [PAY_W-1:0]   rd_pay;
  logic               key_before;

  assign rd_key = ram_rdata[ENTRY_W-1:PAY_W];
  assign rd_pay = ram_rdata[PAY_W-1:0];

  spq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  spq_cmp u_cmp (
    .key_a_i (key_q),
    .key_b_i (rd_key),
    .mode_i  (mode_i),
    .before_o(key_before)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      sh_idx_q <= '0;
      ptr_q    <= '0;
      status_q <= ST_OK;
      pop_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      sh_idx_q <= sh_idx_d;
      ptr_q    <= ptr_d;
      status_q <= status_d;
      pop_q    <= pop_d;
    end
  end

  // Word being worked on
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  // Next state, store access and bookkeeping
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    idx_d     = idx_q;
    sh_idx_d  = sh_idx_q;
    ptr_d     = ptr_q;
    key_d     = key_q;
    pay_d     = pay_q;
    status_d  = status_q;
    pop_d     = pop_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = {key_q, pay_q};
    ram_re    = 1'b0;
    ram_raddr = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d    = key_i;
          pay_d    = payload_i;
          status_d = ST_OK;
          pop_d    = 1'b0;
          if (op_i == OP_POP) begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              state_d   = S_POP;
            end
          end else if (count_q == CNT_W'(DEPTH)) begin
            status_d = ST_FULL;
            state_d  = S_RESP;
          end else begin
            idx_d   = '0;
            ptr_d   = head_q;
            state_d = S_SRCH_RD;
          end
        end
      end
      // Head word now sits in the read register: drop it from the ring
      S_POP: begin
        pop_d   = 1'b1;
        head_d  = ptr_next(head_q);
        count_d = count_q - CNT_W'(1);
        state_d = S_RESP;
      end
      // Walk from the head until the new key precedes a stored one or the end is reached
      S_SRCH_RD: begin
        if (idx_q == count_q) begin
          sh_idx_d = count_q;
          ptr_d    = tail_q;
          state_d  = S_SH_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          state_d   = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (key_before) begin
          sh_idx_d = count_q;
          ptr_d    = tail_q;
          state_d  = S_SH_RD;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          ptr_d   = ptr_next(ptr_q);
          state_d = S_SRCH_RD;
        end
      end
      // Move the tail entries up one slot, then drop the new word in the gap
      S_SH_RD: begin
        if (sh_idx_q == idx_q) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q;
          count_d   = count_q + CNT_W'(1);
          tail_d    = ptr_next(tail_q);
          state_d   = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_prev(ptr_q);
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_prev(ptr_q);
        sh_idx_d  = sh_idx_q - CNT_W'(1);
        state_d   = S_SH_RD;
      end
      // Hold the result until the output register takes it
      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Result word
  always_comb begin
    res_o.req     = (state_q == S_RESP);
    res_o.pop     = pop_q;
    res_o.key     = pop_q ? rd_key : '0;
    res_o.payload = pop_q ? rd_pay : '0;
    res_o.status  = status_q;
    res_o.count   = count_q;
  end

endmodule

@@ rtl/core/sorted_priority_queue_core.sv @@
// Sorted priority queue: top level with register port and output register.
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word: op_i selects
//   push (key_in_i, payload_in_i) or pop of the head entry. Every word gives
//   exactly one result word on the output channel (res_valid_o / res_ready_i)
//   with out_valid_o, out_key_o, out_payload_o, status_o and count_out_o.
//   order_mode (register 0, byte address 0): 0 pops the smallest key first,
//   1 the largest. Equal keys leave in arrival order. Write it only while idle.
// Operation: a pop reads the head entry, then drops it from the ring; a
//   push on full or a pop on empty answers with an error status; a push
//   compares stored entries from the head until the new key precedes one,
//   then moves the entries behind it up one slot and fills the gap. One
//   word is worked on at a time; in_ready_o is high only when idle.
// Reset: empties the queue and clears order_mode; no clearing pass is needed.
// Stall: a result waits in the output register while res_ready_i is low; the
//   next word may be accepted meanwhile, and its result holds in the
//   sequencer until the output register frees up.
`timescale 1ns / 1ps

module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [KEY_W-1:0]  key_in_i,
  input  logic [PAY_W-1:0]  payload_in_i,
  // result channel
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              out_valid_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [PAY_W-1:0]  out_payload_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  count_out_o
);

  logic             order_mode_q;
  logic             reg_wr;
  res_t             res;
  logic             out_free;
  logic             res_valid_q;
  logic             out_valid_q;
  logic [KEY_W-1:0] out_key_q;
  logic [PAY_W-1:0] out_payload_q;
  status_e          status_q;
  logic [CNT_W-1:0] count_q;

  // Register port
  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b0;
    end else if (reg_wr && (paddr[2] == 1'(REG_ORDER_MODE))) begin
      order_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == 1'(REG_ORDER_MODE)) ? {31'd0, order_mode_q} : 32'd0;

  spq_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (order_mode_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .op_i      (op_i),
    .key_i     (key_in_i),
    .payload_i (payload_in_i),
    .res_o     (res),
    .res_take_i(out_free)
  );

  // Output register: load when empty or being drained
  assign out_free = !res_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= res.req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.req) begin
      out_valid_q   <= res.pop;
      out_key_q     <= res.key;
      out_payload_q <= res.payload;
      status_q      <= res.status;
      count_q       <= res.count;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_valid_o   = out_valid_q;
  assign out_key_o     = out_key_q;
  assign out_payload_o = out_payload_q;
  assign status_o      = status_q;
  assign count_out_o   = count_q;

endmodule

@@ rtl/core/spq_checker.sv @@
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_assert.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_o,
  input logic             res_ready_i,
  input logic             out_valid_o,
  input logic [KEY_W-1:0] out_key_o,
  input logic [PAY_W-1:0] out_payload_o,
  input logic [1:0]       status_o,
  input logic [CNT_W-1:0] count_out_o
);

  // A stalled result word holds
  `SPQ_ASSERT_NXT(a_stall_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(out_key_o) && $stable(out_payload_o) && $stable(count_out_o))

  // A returned entry only comes with ok status and leaves room behind it
  `SPQ_ASSERT_IMP(a_pop_ok, res_valid_o && out_valid_o, status_o == ST_OK && count_out_o < CNT_W'(DEPTH))

  // Error results carry no entry
  `SPQ_ASSERT_IMP(a_err_clean, res_valid_o && status_o != ST_OK, !out_valid_o && out_key_o == '0 && out_payload_o == '0)

  // A dropped push means the queue was full, an empty pop means it was empty
  `SPQ_ASSERT_IMP(a_full_cnt, res_valid_o && status_o == ST_FULL, count_out_o == CNT_W'(DEPTH))
  `SPQ_ASSERT_IMP(a_empty_cnt, res_valid_o && status_o == ST_EMPTY, count_out_o == '0)

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
